// ----- rtl/lsst_pkg.sv -----
// ----------------------------------------------------------------------------
// lsst_pkg
// Shared widths, constants, register indexes and structs of the LED strip
// sweep transition block.
// ----------------------------------------------------------------------------
package lsst_pkg;

  localparam int TIME_BITS_DEF  = 48;
  localparam int MAX_PIXELS_DEF = 64;

  localparam int COLOR_W    = 32;
  localparam int PCT_W      = 7;
  localparam int LEN_W      = 7;
  localparam int IDX_W      = 6;
  localparam int CH_W       = 8;
  localparam int TOT_W      = 27;
  localparam int NUM_W      = 34;
  localparam int Q_W        = 7;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam int US_PER_SECOND = 1000000;
  localparam int FULL_PERCENT  = 100;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_COLOR      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BRIGHTNESS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_SECONDS     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_STRIP_LENGTH      = CFG_IDX_W'(3);

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [TOT_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   pos;
    logic [Q_W-1:0]     on_base;
    logic [Q_W-1:0]     on_tgt;
    logic [PCT_W-1:0]   base_bri;
    logic [PCT_W-1:0]   tgt_bri;
    logic [COLOR_W-1:0] base_color;
    logic [COLOR_W-1:0] tgt_color;
  } frame_t;

  typedef struct packed {
    logic busy;
    logic done;
  } emit_status_t;

endpackage

// ----- rtl/lsst_if.sv -----
// ----------------------------------------------------------------------------
// lsst_if
// Valid/ready channels of the sweep block: tick input, pixel output and
// configuration write port.
// ----------------------------------------------------------------------------
interface lsst_in_if #(
  parameter int TIME_BITS = lsst_pkg::TIME_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] now_us;

  modport source (output valid, output now_us, input ready);
  modport sink (input valid, input now_us, output ready);
endinterface

interface lsst_out_if;
  logic                       valid;
  logic                       ready;
  logic [lsst_pkg::IDX_W-1:0] pixel_index;
  logic [lsst_pkg::CH_W-1:0]  pixel_red;
  logic [lsst_pkg::CH_W-1:0]  pixel_green;
  logic [lsst_pkg::CH_W-1:0]  pixel_blue;
  logic [lsst_pkg::CH_W-1:0]  pixel_white;
  logic                       frame_last;

  modport source (output valid, output pixel_index, output pixel_red, output pixel_green,
                  output pixel_blue, output pixel_white, output frame_last, input ready);
  modport sink (input valid, input pixel_index, input pixel_red, input pixel_green,
                input pixel_blue, input pixel_white, input frame_last, output ready);
endinterface

interface lsst_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lsst_pkg::CFG_IDX_W-1:0]  index;
  logic [lsst_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/lsst_div.sv -----
// ----------------------------------------------------------------------------
// lsst_div
// Shared restoring divider, one quotient bit per cycle, for quotients known
// to fit in Q_W bits.
// ----------------------------------------------------------------------------
module lsst_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  lsst_pkg::div_req_t       req,
  output logic                     done,
  output logic [lsst_pkg::Q_W-1:0] quot
);
  import lsst_pkg::*;

  localparam int CNT_W = $clog2(Q_W);

  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] dsh_r, dsh_nxt;
  logic [Q_W-1:0]   q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             ge;

  assign ge   = rem_r >= dsh_r;
  assign quot = {q_r[Q_W-2:0], ge};
  assign done = busy_r && (cnt_r == '0);

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = req.num;
      dsh_nxt  = NUM_W'(req.den) << (Q_W - 1);
      q_nxt    = '0;
      cnt_nxt  = CNT_W'(Q_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsh_r;
      end
      q_nxt   = quot;
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

endmodule

// ----- rtl/lsst_emit.sv -----
// ----------------------------------------------------------------------------
// lsst_emit
// Pixel emitter: walks the strip one pixel per cycle while not stalled, runs
// the two duty accumulators and holds each pixel in an output register.
// ----------------------------------------------------------------------------
module lsst_emit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  lsst_pkg::frame_t       frame,
  output lsst_pkg::emit_status_t status,
  lsst_out_if.source             out_pixel
);
  import lsst_pkg::*;

  frame_t           frame_r;
  logic [LEN_W-1:0] idx_r;
  logic [LEN_W-1:0] acc_b_r, acc_t_r;
  logic             busy_r;
  logic             valid_r;
  logic [IDX_W-1:0] index_r;
  logic [COLOR_W-1:0] color_r;
  logic             last_r;

  logic             advance;
  logic             last_px;
  logic [LEN_W:0]   sum_b, sum_t;
  logic             hit_b, hit_t;
  logic             base_on, tgt_on;
  logic [COLOR_W-1:0] color;

  assign advance = busy_r && (!valid_r || out_pixel.ready);
  assign last_px = (idx_r + LEN_W'(1)) == frame_r.len;

  assign sum_b = {1'b0, acc_b_r} + (LEN_W+1)'(frame_r.on_base);
  assign sum_t = {1'b0, acc_t_r} + (LEN_W+1)'(frame_r.on_tgt);
  assign hit_b = sum_b >= {1'b0, frame_r.len};
  assign hit_t = sum_t >= {1'b0, frame_r.len};

  always_comb begin
    priority if (frame_r.base_bri == '0) begin
      base_on = 1'b0;
    end else if (frame_r.base_bri >= PCT_W'(FULL_PERCENT)) begin
      base_on = 1'b1;
    end else begin
      base_on = hit_b;
    end
    priority if (frame_r.tgt_bri == '0) begin
      tgt_on = 1'b0;
    end else if (frame_r.tgt_bri >= PCT_W'(FULL_PERCENT)) begin
      tgt_on = 1'b1;
    end else begin
      tgt_on = hit_t;
    end
    if (idx_r < frame_r.pos) begin
      color = tgt_on ? frame_r.tgt_color : '0;
    end else begin
      color = base_on ? frame_r.base_color : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      frame_r <= frame;
      idx_r   <= '0;
      acc_b_r <= '0;
      acc_t_r <= '0;
    end else if (advance) begin
      idx_r   <= idx_r + LEN_W'(1);
      acc_b_r <= hit_b ? LEN_W'(sum_b - {1'b0, frame_r.len}) : LEN_W'(sum_b);
      acc_t_r <= hit_t ? LEN_W'(sum_t - {1'b0, frame_r.len}) : LEN_W'(sum_t);
    end
    if (advance) begin
      index_r <= idx_r[IDX_W-1:0];
      color_r <= color;
      last_r  <= last_px;
    end
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
      end else if (advance && last_px) begin
        busy_r <= 1'b0;
      end
      if (advance) begin
        valid_r <= 1'b1;
      end else if (out_pixel.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign status.busy = busy_r;
  assign status.done = advance && last_px;

  assign out_pixel.valid       = valid_r;
  assign out_pixel.pixel_index = index_r;
  assign out_pixel.pixel_red   = color_r[31:24];
  assign out_pixel.pixel_green = color_r[23:16];
  assign out_pixel.pixel_blue  = color_r[15:8];
  assign out_pixel.pixel_white = color_r[7:0];
  assign out_pixel.frame_last  = last_r;

endmodule

// ----- rtl/led_strip_sweep_transition.sv -----
// ----------------------------------------------------------------------------
// led_strip_sweep_transition
// Sweep sequencer, configuration registers and sweep state of the LED strip
// transition block.
// ----------------------------------------------------------------------------
// Each accepted tick starts a sweep when the target colour or brightness has
// changed and the strip length is non-zero, then, while a sweep runs, emits
// one pixel item per strip pixel in index order. A tick is processed as:
// accept in IDLE, the elapsed time in ELAP, the position product and the
// divider start in MUL, then three passes through the shared bit-serial
// divider (sweep position, base and target on-counts in DPOS, DBASE and
// DTGT), then the pixels at one per cycle while the output side takes them.
// A tick with no sweep running or a zero strip length emits nothing and
// leaves the block idle. The next tick can be accepted in the cycle after
// the last pixel enters the output register.
// ----------------------------------------------------------------------------
module led_strip_sweep_transition #(
  parameter int TIME_BITS  = lsst_pkg::TIME_BITS_DEF,
  parameter int MAX_PIXELS = lsst_pkg::MAX_PIXELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lsst_in_if.sink    in_tick,
  lsst_out_if.source out_pixel,
  lsst_cfg_if.sink   cfg_wr
);
  import lsst_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ELAP  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DPOS  = 3'd3;
  localparam logic [2:0] S_DBASE = 3'd4;
  localparam logic [2:0] S_DTGT  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]           state_r, state_nxt;

  logic [COLOR_W-1:0]   tgt_color_r;
  logic [PCT_W-1:0]     tgt_bri_r;
  logic [PCT_W-1:0]     sweep_sec_r;
  logic [LEN_W-1:0]     strip_len_r;

  logic [COLOR_W-1:0]   snap_color_r;
  logic [PCT_W-1:0]     snap_bri_r;
  logic [COLOR_W-1:0]   base_color_r;
  logic [PCT_W-1:0]     base_bri_r;
  logic [TIME_BITS-1:0] start_r;
  logic [TOT_W-1:0]     total_r;
  logic                 active_r;

  logic [TIME_BITS-1:0] now_r;
  logic [LEN_W-1:0]     len_r;
  logic [TOT_W-1:0]     el_r;
  logic                 full_r;
  logic [LEN_W-1:0]     pos_r;
  logic [Q_W-1:0]       on_base_r;

  logic                 in_acc;
  logic [LEN_W-1:0]     len_now;
  logic                 changed;
  logic [PCT_W-1:0]     sec_eff;
  logic [TIME_BITS-1:0] elapsed;
  logic [PCT_W-1:0]     cfg_pct;

  logic                 div_start;
  div_req_t             div_req;
  logic                 div_done;
  logic [Q_W-1:0]       div_quot;

  logic                 emit_start;
  frame_t               frame;
  emit_status_t         emit_st;

  assign in_tick.ready = state_r == S_IDLE;
  assign cfg_wr.ready  = 1'b1;
  assign in_acc        = in_tick.valid && in_tick.ready;

  assign len_now = (strip_len_r > LEN_W'(MAX_PIXELS)) ? LEN_W'(MAX_PIXELS) : strip_len_r;
  assign changed = (tgt_color_r != snap_color_r) || (tgt_bri_r != snap_bri_r);
  assign sec_eff = (sweep_sec_r == '0) ? PCT_W'(1) : sweep_sec_r;
  assign elapsed = now_r - start_r;
  assign cfg_pct = (cfg_wr.data[PCT_W-1:0] > PCT_W'(FULL_PERCENT)) ? PCT_W'(FULL_PERCENT)
                                                                   : cfg_wr.data[PCT_W-1:0];

  // divider requests: position in MUL, on-counts after each result
  always_comb begin
    div_start = 1'b0;
    div_req   = '0;
    unique case (state_r)
      S_MUL: begin
        div_start   = 1'b1;
        div_req.num = NUM_W'(len_r) * NUM_W'(el_r);
        div_req.den = total_r;
      end
      S_DPOS: begin
        div_start   = div_done;
        div_req.num = NUM_W'(len_r) * NUM_W'(base_bri_r);
        div_req.den = TOT_W'(FULL_PERCENT);
      end
      S_DBASE: begin
        div_start   = div_done;
        div_req.num = NUM_W'(len_r) * NUM_W'(tgt_bri_r);
        div_req.den = TOT_W'(FULL_PERCENT);
      end
      default: begin
      end
    endcase
  end

  assign emit_start       = (state_r == S_DTGT) && div_done;
  assign frame.len        = len_r;
  assign frame.pos        = pos_r;
  assign frame.on_base    = on_base_r;
  assign frame.on_tgt     = div_quot;
  assign frame.base_bri   = base_bri_r;
  assign frame.tgt_bri    = tgt_bri_r;
  assign frame.base_color = base_color_r;
  assign frame.tgt_color  = tgt_color_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (len_now != '0) && (changed || active_r)) begin
          state_nxt = S_ELAP;
        end
      end
      S_ELAP:  state_nxt = S_MUL;
      S_MUL:   state_nxt = S_DPOS;
      S_DPOS:  if (div_done) state_nxt = S_DBASE;
      S_DBASE: if (div_done) state_nxt = S_DTGT;
      S_DTGT:  if (div_done) state_nxt = S_EMIT;
      S_EMIT:  if (emit_st.done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r <= in_tick.now_us;
      len_r <= len_now;
    end
    if (state_r == S_ELAP) begin
      el_r   <= elapsed[TOT_W-1:0];
      full_r <= elapsed >= TIME_BITS'(total_r);
    end
    if ((state_r == S_DPOS) && div_done) begin
      pos_r <= full_r ? len_r : LEN_W'(div_quot);
    end
    if ((state_r == S_DBASE) && div_done) begin
      on_base_r <= div_quot;
    end
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tgt_color_r  <= '0;
      tgt_bri_r    <= PCT_W'(FULL_PERCENT);
      sweep_sec_r  <= PCT_W'(1);
      strip_len_r  <= LEN_W'(64);
      snap_color_r <= '0;
      snap_bri_r   <= PCT_W'(FULL_PERCENT);
      base_color_r <= '0;
      base_bri_r   <= '0;
      start_r      <= '0;
      total_r      <= TOT_W'(US_PER_SECOND);
      active_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr.valid && cfg_wr.ready) begin
        unique case (cfg_wr.index)
          REG_TARGET_COLOR:      tgt_color_r <= cfg_wr.data[COLOR_W-1:0];
          REG_TARGET_BRIGHTNESS: tgt_bri_r   <= cfg_pct;
          REG_SWEEP_SECONDS:     sweep_sec_r <= cfg_pct;
          REG_STRIP_LENGTH:      strip_len_r <= cfg_wr.data[LEN_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_acc && (len_now != '0) && changed) begin
        snap_color_r <= tgt_color_r;
        snap_bri_r   <= tgt_bri_r;
        start_r      <= in_tick.now_us;
        total_r      <= TOT_W'(sec_eff) * TOT_W'(US_PER_SECOND);
        active_r     <= 1'b1;
      end
      // sweep complete: target becomes the base
      if (emit_start && (pos_r >= len_r)) begin
        base_color_r <= tgt_color_r;
        base_bri_r   <= tgt_bri_r;
        active_r     <= 1'b0;
      end
    end
  end

  lsst_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  lsst_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (emit_start),
    .frame     (frame),
    .status    (emit_st),
    .out_pixel (out_pixel)
  );

`ifndef SYNTH
  a_div_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DPOS) || (state_r == S_DBASE) || (state_r == S_DTGT))
    else $error("divider finished outside a divide state");

  a_pos_within_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (pos_r <= len_r))
    else $error("sweep position beyond strip length");

  a_emit_only_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit_st.busy |-> (state_r == S_EMIT))
    else $error("emitter busy outside emit state");

  a_sweep_end_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(active_r) |-> ($past(state_r) == S_DTGT))
    else $error("sweep ended without a completed frame");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for led_strip_sweep_transition. Ticks go in on a
// bursty valid/ready channel and pixel items come out under a rotating stall
// pattern. A frame predictor built into the bench tracks the configuration
// and the sweep state. For every accepted tick it queues the pixel items
// that tick should produce, and each pixel item that comes out is checked
// field by field against the head of that queue.
// ----------------------------------------------------------------------------
module tb_top;
  import lsst_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 9;
  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_TICKS   = 440;
  localparam int STRIP_MAX      = MAX_PIXELS_DEF;

  localparam logic [CFG_IDX_W-1:0]     REG_SPARE_FIRST = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0]     REG_SPARE_LAST  = '1;
  localparam logic [TIME_BITS_DEF-1:0] TIME_TOP        = '1;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  white;
    logic             last;
  } pixel_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic pix_ready = 1'b0;

  lsst_in_if  tick_ch ();
  lsst_out_if pix_ch ();
  lsst_cfg_if cfg_ch ();

  assign pix_ch.ready = pix_ready;

  led_strip_sweep_transition i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tick   (tick_ch),
    .out_pixel (pix_ch),
    .cfg_wr    (cfg_ch)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // predicted registers and sweep state
  logic [COLOR_W-1:0]       tgt_color      = '0;
  logic [COLOR_W-1:0]       snap_color     = '0;
  logic [COLOR_W-1:0]       base_color     = '0;
  logic [PCT_W-1:0]         tgt_pct        = PCT_W'(100);
  logic [PCT_W-1:0]         snap_pct       = PCT_W'(100);
  logic [PCT_W-1:0]         base_pct       = '0;
  logic [PCT_W-1:0]         sweep_secs_cfg = PCT_W'(1);
  logic [PCT_W-1:0]         dur_s          = '0;
  logic [LEN_W-1:0]         strip_cfg      = LEN_W'(64);
  logic [TIME_BITS_DEF-1:0] sweep_t0       = '0;
  logic                     sweeping       = 1'b0;

  pixel_t      pixel_q[$];
  pixel_t      head_px;
  int          mismatch_cnt = 0;
  int          tick_cnt     = 0;
  int          burst_left   = 0;
  int          quiet_cycles = 0;
  logic [15:0] stall_pat    = 16'hFFFF;
  int          stall_hold   = 0;

  function automatic logic [PCT_W-1:0] clip_pct(logic [CFG_DATA_W-1:0] data);
    return (data[PCT_W-1:0] > FULL_PERCENT) ? PCT_W'(FULL_PERCENT) : data[PCT_W-1:0];
  endfunction

  function automatic bit duty_lit(logic [PCT_W-1:0] pct, int unsigned on_cnt,
                                  int unsigned span, inout int unsigned acc);
    if (pct == 0) return 1'b0;
    if (pct >= FULL_PERCENT) return 1'b1;
    acc += on_cnt;
    if (acc >= span) begin
      acc -= span;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [TIME_BITS_DEF-1:0] rand_time();
    return TIME_BITS_DEF'({$urandom, $urandom});
  endfunction

  function automatic void predict_frame(logic [TIME_BITS_DEF-1:0] now);
    int unsigned              n;
    int unsigned              pos;
    int unsigned              on_b;
    int unsigned              on_t;
    int unsigned              acc_b;
    int unsigned              acc_t;
    longint unsigned          span_us;
    longint unsigned          elapsed;
    logic [TIME_BITS_DEF-1:0] delta;
    logic [COLOR_W-1:0]       c;
    bit                       b_on;
    bit                       t_on;
    n = (strip_cfg > STRIP_MAX) ? STRIP_MAX : strip_cfg;
    if (n == 0) return;
    if (tgt_color != snap_color || tgt_pct != snap_pct) begin
      sweep_t0   = now;
      dur_s      = (sweep_secs_cfg == 0) ? PCT_W'(1) : sweep_secs_cfg;
      snap_color = tgt_color;
      snap_pct   = tgt_pct;
      sweeping   = 1'b1;
    end
    if (!sweeping) return;
    span_us = longint'((dur_s == 0) ? 1 : dur_s) * US_PER_SECOND;
    delta   = now - sweep_t0;
    elapsed = delta;
    if (elapsed >= span_us) pos = n;
    else pos = (n * elapsed) / span_us;
    if (pos > n) pos = n;
    on_b  = (n * base_pct) / FULL_PERCENT;
    on_t  = (n * tgt_pct) / FULL_PERCENT;
    acc_b = 0;
    acc_t = 0;
    for (int unsigned i = 0; i < n; i++) begin
      b_on = duty_lit(base_pct, on_b, n, acc_b);
      t_on = duty_lit(tgt_pct, on_t, n, acc_t);
      c    = '0;
      if (i < pos) begin
        if (t_on) c = tgt_color;
      end else if (b_on) begin
        c = base_color;
      end
      pixel_q.push_back('{IDX_W'(i), c[31:24], c[23:16], c[15:8], c[7:0], i + 1 == n});
    end
    if (pos >= n) begin
      base_color = tgt_color;
      base_pct   = tgt_pct;
      sweeping   = 1'b0;
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  task automatic send_tick(input logic [TIME_BITS_DEF-1:0] now);
    int gap;
    cfg_ch.valid <= 1'b0;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        tick_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    tick_ch.valid  <= 1'b1;
    tick_ch.now_us <= now;
    do @(posedge clk); while (!tick_ch.ready);
    predict_frame(now);
    burst_left--;
    tick_cnt++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    unique case (index)
      REG_TARGET_COLOR:      tgt_color = data;
      REG_TARGET_BRIGHTNESS: tgt_pct = clip_pct(data);
      REG_SWEEP_SECONDS:     sweep_secs_cfg = clip_pct(data);
      REG_STRIP_LENGTH:      strip_cfg = data[LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    tick_ch.valid <= 1'b0;
    cfg_ch.valid  <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_idle_ticks();
    send_tick('0);
    send_tick(TIME_TOP);
  endtask

  task automatic test_length_limits();
    logic [TIME_BITS_DEF-1:0] t0;
    t0 = TIME_TOP - TIME_BITS_DEF'(65535);
    wait_idle();
    write_reg(REG_TARGET_COLOR, '1);
    write_reg(REG_STRIP_LENGTH, '0);
    send_tick(TIME_BITS_DEF'(1000));
    wait_idle();
    write_reg(REG_STRIP_LENGTH, 32'd127);
    write_reg(REG_SWEEP_SECONDS, '0);
    // sweep straddles the time wrap
    send_tick(t0);
    send_tick(t0 + TIME_BITS_DEF'(500000));
    send_tick(t0 + TIME_BITS_DEF'(999999));
    send_tick(t0 + TIME_BITS_DEF'(1000000));
  endtask

  task automatic test_brightness_and_duration();
    logic [TIME_BITS_DEF-1:0] t0;
    t0 = TIME_BITS_DEF'(48'h0000_1234_5678);
    wait_idle();
    write_reg(REG_TARGET_COLOR, 32'h8040_2010);
    write_reg(REG_TARGET_BRIGHTNESS, 32'hFFFF_FF80);
    write_reg(REG_SWEEP_SECONDS, 32'd127);
    write_reg(REG_STRIP_LENGTH, 32'd1);
    send_tick(t0);
    send_tick(t0 + TIME_BITS_DEF'(50000000));
    send_tick(t0 + TIME_BITS_DEF'(100000000));
    wait_idle();
    write_reg(REG_TARGET_BRIGHTNESS, 32'd127);
    write_reg(REG_TARGET_COLOR, 32'h00FF_00FF);
    write_reg(REG_SWEEP_SECONDS, 32'd2);
    write_reg(REG_STRIP_LENGTH, 32'd65);
    send_tick(t0);
    send_tick(t0 + TIME_BITS_DEF'(700000));
    send_tick(t0 + TIME_BITS_DEF'(1500000));
    // restart while the previous sweep is still running
    wait_idle();
    write_reg(REG_TARGET_BRIGHTNESS, 32'd50);
    write_reg(REG_SWEEP_SECONDS, 32'd1);
    write_reg(REG_STRIP_LENGTH, 32'd37);
    send_tick(t0 + TIME_BITS_DEF'(2000000));
    send_tick(t0 + TIME_BITS_DEF'(2600000));
    send_tick(t0 + TIME_BITS_DEF'(3000000));
    wait_idle();
    write_reg(REG_TARGET_BRIGHTNESS, 32'd33);
    write_reg(REG_STRIP_LENGTH, 32'd64);
    send_tick(t0 + TIME_BITS_DEF'(4000000));
    send_tick(t0 + TIME_BITS_DEF'(5000000));
  endtask

  task automatic test_spare_registers();
    wait_idle();
    write_reg(REG_SPARE_FIRST, '1);
    write_reg(REG_SPARE_LAST, '1);
    send_tick('0);
    wait_idle();
    write_reg(REG_TARGET_BRIGHTNESS, 32'd100);
    write_reg(REG_TARGET_COLOR, 32'hA5A5_5A5A);
    send_tick(TIME_BITS_DEF'(10));
    send_tick(TIME_BITS_DEF'(1000010));
  endtask

  task automatic test_random_sweeps();
    logic [TIME_BITS_DEF-1:0] now_t;
    int unsigned              span_us;
    int                       first;
    now_t = rand_time();
    first = tick_cnt;
    while (tick_cnt - first < RANDOM_TICKS) begin
      wait_idle();
      if ($urandom_range(0, 3) != 0) write_reg(REG_TARGET_COLOR, $urandom);
      case ($urandom_range(0, 4))
        0: write_reg(REG_TARGET_BRIGHTNESS, $urandom);
        1: write_reg(REG_TARGET_BRIGHTNESS, FULL_PERCENT);
        2: write_reg(REG_TARGET_BRIGHTNESS, $urandom_range(0, 100));
        3: write_reg(REG_TARGET_BRIGHTNESS, '0);
        default: ;
      endcase
      case ($urandom_range(0, 5))
        0: write_reg(REG_SWEEP_SECONDS, $urandom_range(0, 127));
        1: write_reg(REG_SWEEP_SECONDS, $urandom);
        2, 3: write_reg(REG_SWEEP_SECONDS, $urandom_range(0, 2));
        default: ;
      endcase
      case ($urandom_range(0, 7))
        0: write_reg(REG_STRIP_LENGTH, $urandom_range(65, 127));
        1: write_reg(REG_STRIP_LENGTH, '0);
        2: write_reg(REG_STRIP_LENGTH, $urandom);
        3, 4: write_reg(REG_STRIP_LENGTH, $urandom_range(1, 64));
        default: ;
      endcase
      if ($urandom_range(0, 7) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom);
      span_us = ((sweep_secs_cfg == 0) ? 1 : sweep_secs_cfg) * US_PER_SECOND;
      repeat ($urandom_range(3, 16)) begin
        case ($urandom_range(0, 19))
          0: now_t = rand_time();
          1: now_t = TIME_TOP - TIME_BITS_DEF'($urandom_range(0, span_us));
          2: ;
          3: now_t = now_t + TIME_BITS_DEF'(span_us + $urandom_range(0, span_us));
          default: now_t = now_t + TIME_BITS_DEF'($urandom_range(0, span_us / 3));
        endcase
        send_tick(now_t);
      end
    end
  endtask

  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_pat  <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      stall_hold <= $urandom_range(40, 400);
    end else begin
      stall_pat  <= {stall_pat[0], stall_pat[15:1]};
      stall_hold <= stall_hold - 1;
    end
    pix_ready <= stall_pat[0];
  end

  always @(posedge clk) begin
    if (rst_n && pix_ch.valid && pix_ch.ready) begin
      if (pixel_q.size() == 0) begin
        $error("pixel item %0d with no frame pending", pix_ch.pixel_index);
        mismatch_cnt++;
      end else begin
        head_px = pixel_q.pop_front();
        check_field("pixel_index", head_px.index, pix_ch.pixel_index);
        check_field("pixel_red", head_px.red, pix_ch.pixel_red);
        check_field("pixel_green", head_px.green, pix_ch.pixel_green);
        check_field("pixel_blue", head_px.blue, pix_ch.pixel_blue);
        check_field("pixel_white", head_px.white, pix_ch.pixel_white);
        check_field("frame_last", head_px.last, pix_ch.frame_last);
      end
    end
  end

  always @(posedge clk) begin
    if ((tick_ch.valid && tick_ch.ready) || (pix_ch.valid && pix_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    tick_ch.valid  = 1'b0;
    tick_ch.now_us = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_ticks();
    test_length_limits();
    test_brightness_and_duration();
    test_spare_registers();
    test_random_sweeps();
    wait_idle();
    if (mismatch_cnt == 0 && pixel_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lsst_pkg.sv
rtl/lsst_if.sv
rtl/lsst_div.sv
rtl/lsst_emit.sv
rtl/led_strip_sweep_transition.sv
tb/sv/tb_top.sv
